// ===== rtl/bhs_pkg.sv =====
package bhs_pkg;

    localparam int MAX_DIM     = 256;
    localparam int COORD_W     = 8;
    localparam int PIX_W       = 8;
    localparam int DIM_W       = 9;
    localparam int GAIN_W      = 16;
    localparam int CFG_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = COORD_W + FRAC_W;
    localparam int DIV1_STEPS  = 2 * COORD_W + FRAC_W;
    localparam int QUOT_W      = 24;
    localparam int DIV2_STEPS  = QUOT_W;
    localparam int DEN_W       = 25;
    localparam int HALF_W      = 24;
    localparam int HEIGHT_W    = 24;
    localparam int FADE_SCALE  = 20;
    localparam int DEN_SCALE   = 256 * 255;
    localparam int HALF_SCALE  = DEN_SCALE / 2;
    localparam int BANK_AW     = 2 * (COORD_W - 1);
    localparam int BANK_DEPTH  = 1 << BANK_AW;

    localparam logic [DIM_W-1:0]           WIDTH_RESET  = 9'd256;
    localparam logic [DIM_W-1:0]           HEIGHT_RESET = 9'd256;
    localparam logic [DIM_W-1:0]           GRID_RESET   = 9'd64;
    localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = 16'sd256;
    localparam logic [HEIGHT_W-1:0]        HEIGHT_POS_MAX = 24'h7FFFFF;
    localparam logic [HEIGHT_W-1:0]        HEIGHT_NEG_MAX = 24'h800000;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_GRID_SAMPLES = 2'd2,
        REG_DISP_GAIN    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    // One axis of the position divider: numerator shifting out, remainder, quotient.
    typedef struct packed {
        logic [DIV1_STEPS-1:0] n;
        logic [DIM_W-1:0]      r;
        logic [POS_W-1:0]      q;
    } div_t;

    typedef struct packed {
        action_t          action;
        logic [7:0]       px;
        logic [7:0]       py;
        logic [7:0]       val;
        logic [DIM_W-1:0] e;
        div_t             u;
        div_t             v;
    } pos_stage_t;

    typedef struct packed {
        logic              ov;
        logic              neg;
        logic [DEN_W-1:0]  r;
        logic [QUOT_W-1:0] n;
        logic [QUOT_W-1:0] q;
    } quot_stage_t;

    function automatic div_t div_step(div_t s, logic [DIM_W-1:0] d);
        logic [DIM_W:0] t;
        div_t           o;
        t   = {s.r, s.n[DIV1_STEPS-1]};
        o.n = {s.n[DIV1_STEPS-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            o.r = DIM_W'(t - {1'b0, d});
            o.q = {s.q[POS_W-2:0], 1'b1};
        end
        else
        begin
            o.r = t[DIM_W-1:0];
            o.q = {s.q[POS_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic quot_stage_t quot_step(quot_stage_t s, logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        quot_stage_t    o;
        t     = {s.r, s.n[QUOT_W-1]};
        o.ov  = s.ov;
        o.neg = s.neg;
        o.n   = {s.n[QUOT_W-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            o.r = DEN_W'(t - {1'b0, d});
            o.q = {s.q[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            o.r = t[DEN_W-1:0];
            o.q = {s.q[QUOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== rtl/bilinear_heightfield_sampler_core.sv =====
// A sample beat runs through the position divider, the bank read and blend stages,
// the rounding divider and the output register. Throughput: one beat per cycle;
// every stage is a register and stalls only when the output register holds a beat
// that is not taken. Depth comes from the 32 one-bit position divider stages and
// the 24 stages of the final rounding divider. Reset clears valid bits and loads the
// config reset values; the pixel store is not cleared and holds garbage until written.
module bilinear_heightfield_sampler_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [bhs_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [7:0]                          pixel_x,
    input  logic [7:0]                          pixel_y,
    input  logic [7:0]                          pixel_value,
    input  logic [7:0]                          grid_x,
    input  logic [7:0]                          grid_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bhs_pkg::HEIGHT_W-1:0] height
);

    localparam int NQ = bhs_pkg::DIV1_STEPS;
    localparam int NR = bhs_pkg::DIV2_STEPS;

    logic [bhs_pkg::DIM_W-1:0]         width_reg;
    logic [bhs_pkg::DIM_W-1:0]         heightdim_reg;
    logic [bhs_pkg::DIM_W-1:0]         grid_reg;
    logic signed [bhs_pkg::GAIN_W-1:0] gain_reg;

    logic                              adv;
    logic [7:0]                        w1;
    logic [7:0]                        h1;
    logic [bhs_pkg::DIM_W-1:0]         g1;
    logic [bhs_pkg::DEN_W-1:0]         den;
    logic [bhs_pkg::HALF_W-1:0]        half;
    logic [bhs_pkg::GAIN_W-1:0]        gabs;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= bhs_pkg::WIDTH_RESET;
            heightdim_reg <= bhs_pkg::HEIGHT_RESET;
            grid_reg      <= bhs_pkg::GRID_RESET;
            gain_reg      <= bhs_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (bhs_pkg::cfg_reg_t'(cfg_index))
                bhs_pkg::REG_IMAGE_WIDTH:  width_reg     <= cfg_data[bhs_pkg::DIM_W-1:0];
                bhs_pkg::REG_IMAGE_HEIGHT: heightdim_reg <= cfg_data[bhs_pkg::DIM_W-1:0];
                bhs_pkg::REG_GRID_SAMPLES: grid_reg      <= cfg_data[bhs_pkg::DIM_W-1:0];
                bhs_pkg::REG_DISP_GAIN:    gain_reg      <= $signed(cfg_data);
                default:                   ;
            endcase
        end
    end

    // The user keeps configuration static while beats are in flight (unchecked), so all stages share these.
    always_comb
    begin
        if (width_reg == '0)
            w1 = '0;
        else if (width_reg > bhs_pkg::DIM_W'(bhs_pkg::MAX_DIM))
            w1 = 8'(bhs_pkg::MAX_DIM - 1);
        else
            w1 = 8'(width_reg - 9'd1);

        if (heightdim_reg == '0)
            h1 = '0;
        else if (heightdim_reg > bhs_pkg::DIM_W'(bhs_pkg::MAX_DIM))
            h1 = 8'(bhs_pkg::MAX_DIM - 1);
        else
            h1 = 8'(heightdim_reg - 9'd1);

        if (grid_reg < 9'd2)
            g1 = 9'd1;
        else
            g1 = grid_reg - 9'd1;

        den  = bhs_pkg::DEN_W'(g1 * bhs_pkg::DEN_SCALE);
        half = bhs_pkg::HALF_W'(g1 * bhs_pkg::HALF_SCALE);
        gabs = gain_reg[bhs_pkg::GAIN_W-1] ? bhs_pkg::GAIN_W'(-gain_reg)
                                          : bhs_pkg::GAIN_W'(gain_reg);
    end

    logic out_valid_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------- position dividers ----------------
    logic [7:0]                gcx;
    logic [7:0]                gcz;
    logic [7:0]                gmin;
    logic [12:0]               e20;
    bhs_pkg::pos_stage_t       pos_in;
    bhs_pkg::pos_stage_t       dv_reg   [0:NQ];
    bhs_pkg::pos_stage_t       dv_next  [1:NQ];
    logic                      dv_valid_reg [0:NQ];

    always_comb
    begin
        gcx  = ({1'b0, grid_x} > g1) ? g1[7:0] : grid_x;
        gcz  = ({1'b0, grid_z} > g1) ? g1[7:0] : grid_z;
        gmin = (grid_x < grid_z) ? grid_x : grid_z;
        e20  = 13'(gmin * bhs_pkg::FADE_SCALE);

        pos_in.action = bhs_pkg::action_t'(action);
        pos_in.px     = pixel_x;
        pos_in.py     = pixel_y;
        pos_in.val    = pixel_value;
        pos_in.e      = ({4'b0, g1} < e20) ? g1 : e20[bhs_pkg::DIM_W-1:0];
        pos_in.u.n    = {16'(gcx * w1), {bhs_pkg::FRAC_W{1'b0}}};
        pos_in.u.r    = '0;
        pos_in.u.q    = '0;
        pos_in.v.n    = {16'(gcz * h1), {bhs_pkg::FRAC_W{1'b0}}};
        pos_in.v.r    = '0;
        pos_in.v.q    = '0;

        for (int k = 1; k <= NQ; k++)
        begin
            dv_next[k]   = dv_reg[k-1];
            dv_next[k].u = bhs_pkg::div_step(dv_reg[k-1].u, g1);
            dv_next[k].v = bhs_pkg::div_step(dv_reg[k-1].v, g1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NQ; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= in_valid;
            for (int k = 1; k <= NQ; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= pos_in;
            for (int k = 1; k <= NQ; k++)
                dv_reg[k] <= dv_next[k];
        end
    end

    // ---------------- pixel store ----------------
    // Four banks by column and row parity, so the 2x2 neighborhood is one read per bank.
    // Writes travel down the pipe and land here, keeping them in order with samples.
    bhs_pkg::pos_stage_t pos;
    logic [7:0]          x0;
    logic [7:0]          y0;
    logic                pos_valid;
    logic [7:0]          bank_rd [0:3];

    assign pos       = dv_reg[NQ];
    assign pos_valid = dv_valid_reg[NQ];
    assign x0        = pos.u.q[bhs_pkg::POS_W-1:bhs_pkg::FRAC_W];
    assign y0        = pos.v.q[bhs_pkg::POS_W-1:bhs_pkg::FRAC_W];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BX = (b % 2) == 1;
        localparam logic BY = (b / 2) == 1;
        logic [7:0]                 mem [0:bhs_pkg::BANK_DEPTH-1];
        logic [7:0]                 rd_reg;
        logic [7:0]                 xa;
        logic [7:0]                 ya;
        logic [bhs_pkg::BANK_AW-1:0] raddr;
        logic [bhs_pkg::BANK_AW-1:0] waddr;
        logic                       we;

        // The upper neighbor may wrap past the edge only when its weight is zero.
        assign xa    = x0 + {7'b0, x0[0] ^ BX};
        assign ya    = y0 + {7'b0, y0[0] ^ BY};
        assign raddr = {ya[7:1], xa[7:1]};
        assign waddr = {pos.py[7:1], pos.px[7:1]};
        assign we    = pos_valid && (pos.action == bhs_pkg::ACT_WRITE)
                       && (pos.px[0] == BX) && (pos.py[0] == BY);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (we)
                    mem[waddr] <= pos.val;
                rd_reg <= mem[raddr];
            end
        end

        assign bank_rd[b] = rd_reg;
    end

    logic                          mp_valid_reg;
    logic [bhs_pkg::FRAC_W-1:0]    mp_fx_reg;
    logic [bhs_pkg::FRAC_W-1:0]    mp_fy_reg;
    logic [bhs_pkg::DIM_W-1:0]     mp_e_reg;
    logic                          mp_xp_reg;
    logic                          mp_yp_reg;

    // ---------------- blend and scale ----------------
    logic [7:0]          b00;
    logic [7:0]          b10;
    logic [7:0]          b01;
    logic [7:0]          b11;
    logic signed [8:0]   dx0;
    logic signed [8:0]   dx1;
    logic signed [25:0]  prod0;
    logic signed [25:0]  prod1;
    logic signed [25:0]  b1_r0_next;
    logic signed [25:0]  b1_r1_next;
    logic signed [25:0]  b1_r0_reg;
    logic signed [25:0]  b1_r1_reg;
    logic [bhs_pkg::FRAC_W-1:0] b1_fy_reg;
    logic [bhs_pkg::DIM_W-1:0]  b1_e_reg;
    logic                b1_valid_reg;

    logic signed [25:0]  rdiff;
    logic signed [42:0]  b2_p_next;
    logic signed [42:0]  b2_p_reg;
    logic signed [25:0]  b2_r0_reg;
    logic [bhs_pkg::DIM_W-1:0] b2_e_reg;
    logic                b2_valid_reg;

    logic signed [43:0]  bsum;
    logic [23:0]         b3_b16_next;
    logic [23:0]         b3_b16_reg;
    logic [bhs_pkg::DIM_W-1:0] b3_e_reg;
    logic                b3_valid_reg;

    logic [32:0]         b4_a_next;
    logic [32:0]         b4_a_reg;
    logic                b4_valid_reg;

    logic [48:0]         b5_n_next;
    logic [48:0]         b5_n_reg;
    logic                b5_valid_reg;

    logic [49:0]         b6_m_next;
    logic [49:0]         b6_m_reg;
    logic                b6_valid_reg;

    always_comb
    begin
        // A neighbor with zero weight may lie outside the image and never have been
        // written, so it is replaced by a pixel already in the blend.
        b00 = bank_rd[{mp_yp_reg,  mp_xp_reg}];
        b10 = (mp_fx_reg == '0) ? b00 : bank_rd[{mp_yp_reg, !mp_xp_reg}];
        b01 = (mp_fy_reg == '0) ? b00 : bank_rd[{!mp_yp_reg,  mp_xp_reg}];
        if (mp_fx_reg == '0)
            b11 = b01;
        else if (mp_fy_reg == '0)
            b11 = b10;
        else
            b11 = bank_rd[{!mp_yp_reg, !mp_xp_reg}];
        dx0 = $signed({1'b0, b10}) - $signed({1'b0, b00});
        dx1 = $signed({1'b0, b11}) - $signed({1'b0, b01});
        prod0 = dx0 * $signed({1'b0, mp_fx_reg});
        prod1 = dx1 * $signed({1'b0, mp_fx_reg});
        b1_r0_next = $signed({2'b00, b00, 16'h0000}) + prod0;
        b1_r1_next = $signed({2'b00, b01, 16'h0000}) + prod1;

        rdiff     = b1_r1_reg - b1_r0_reg;
        b2_p_next = rdiff * $signed({1'b0, b1_fy_reg});

        // Round the Q.32 blend half up to Q.16; the blend is never negative.
        bsum = (44'(b2_r0_reg) <<< 16) + 44'(b2_p_reg) + 44'sd32768;
        b3_b16_next = bsum[39:16];

        b4_a_next = 33'(b3_b16_reg * b3_e_reg);
        b5_n_next = 49'(b4_a_reg * gabs);
        b6_m_next = 50'(b5_n_reg) + 50'(half);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mp_valid_reg <= pos_valid && (pos.action == bhs_pkg::ACT_SAMPLE);
            b1_valid_reg <= mp_valid_reg;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
            b6_valid_reg <= b5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp_fx_reg  <= pos.u.q[bhs_pkg::FRAC_W-1:0];
            mp_fy_reg  <= pos.v.q[bhs_pkg::FRAC_W-1:0];
            mp_e_reg   <= pos.e;
            mp_xp_reg  <= x0[0];
            mp_yp_reg  <= y0[0];
            b1_r0_reg  <= b1_r0_next;
            b1_r1_reg  <= b1_r1_next;
            b1_fy_reg  <= mp_fy_reg;
            b1_e_reg   <= mp_e_reg;
            b2_p_reg   <= b2_p_next;
            b2_r0_reg  <= b1_r0_reg;
            b2_e_reg   <= b1_e_reg;
            b3_b16_reg <= b3_b16_next;
            b3_e_reg   <= b2_e_reg;
            b4_a_reg   <= b4_a_next;
            b5_n_reg   <= b5_n_next;
            b6_m_reg   <= b6_m_next;
        end
    end

    // ---------------- rounding divider ----------------
    bhs_pkg::quot_stage_t qd_reg  [0:NR];
    bhs_pkg::quot_stage_t qd_next [0:NR];
    logic                 qd_valid_reg [0:NR];
    logic [25:0]          mhi;

    always_comb
    begin
        mhi            = b6_m_reg[49:24];
        // A high part at or above the divisor means the quotient needs more
        // than 24 bits, which always saturates.
        qd_next[0].ov  = mhi >= {1'b0, den};
        qd_next[0].neg = gain_reg[bhs_pkg::GAIN_W-1];
        qd_next[0].r   = mhi[bhs_pkg::DEN_W-1:0];
        qd_next[0].n   = b6_m_reg[23:0];
        qd_next[0].q   = '0;
        for (int k = 1; k <= NR; k++)
            qd_next[k] = bhs_pkg::quot_step(qd_reg[k-1], den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NR; k++)
                qd_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            qd_valid_reg[0] <= b6_valid_reg;
            for (int k = 1; k <= NR; k++)
                qd_valid_reg[k] <= qd_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NR; k++)
                qd_reg[k] <= qd_next[k];
        end
    end

    // ---------------- saturation and output register ----------------
    bhs_pkg::quot_stage_t           qf;
    logic [bhs_pkg::HEIGHT_W-1:0]   height_next;
    logic [bhs_pkg::HEIGHT_W-1:0]   height_reg;

    assign qf = qd_reg[NR];

    always_comb
    begin
        if (qf.ov)
            height_next = qf.neg ? bhs_pkg::HEIGHT_NEG_MAX : bhs_pkg::HEIGHT_POS_MAX;
        else if (!qf.neg)
            height_next = qf.q[bhs_pkg::QUOT_W-1] ? bhs_pkg::HEIGHT_POS_MAX : qf.q;
        else if (qf.q > bhs_pkg::HEIGHT_NEG_MAX)
            height_next = bhs_pkg::HEIGHT_NEG_MAX;
        else
            height_next = bhs_pkg::HEIGHT_W'(-qf.q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= qd_valid_reg[NR];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            height_reg <= height_next;
    end

    assign out_valid = out_valid_reg;
    assign height    = $signed(height_reg);

`ifndef ASSERT_OFF
    // A pixel write never turns into a result beat.
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && pos_valid && (pos.action == bhs_pkg::ACT_WRITE) |=> !mp_valid_reg)
        else $error("write beat reached the blend stages");

    // The position divider leaves a remainder below the divisor.
    a_pos_rem: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid |-> (pos.u.r < g1) && (pos.v.r < g1))
        else $error("position divider remainder out of range");

    // The sample position never passes the last image column or row.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && (pos.action == bhs_pkg::ACT_SAMPLE) |-> (x0 <= w1) && (y0 <= h1)
        && ((x0 != w1) || (pos.u.q[bhs_pkg::FRAC_W-1:0] == '0)))
        else $error("sample position beyond image edge");

    // Without overflow the rounding divider keeps its remainder below the divisor.
    a_quot_rem: assert property (@(posedge clk) disable iff (!rst_n)
        qd_valid_reg[NR] && !qf.ov |-> qf.r < den)
        else $error("rounding divider remainder out of range");
`endif

endmodule
